/* rtl/core/msne_pkg.sv */
// ----------------------------------------------------------------------------
// msne_pkg - shared types and constants for the note extractor
// Record layout, command codes, register indexes and parameter defaults.
// ----------------------------------------------------------------------------
package msne_pkg;

    // parameter defaults
    localparam int CHANNELS_DEF   = 4;
    localparam int COUNT_BITS_DEF = 16;

    // channels a command byte can address (two channel bits)
    localparam int ADDR_CHANNELS = 4;

    // result queue
    localparam int RESULT_DEPTH = 2;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_OFFSET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_OFFSET   = 1'd1;
    localparam logic [CFG_DATA_W-1:0] SQUARE_OFFSET_RST = 7'd24;
    localparam logic [CFG_DATA_W-1:0] WAVE_OFFSET_RST   = 7'd12;

    // sequence byte codes
    localparam logic [7:0] DURATION_MAX = 8'h7F;
    localparam logic [7:0] CMD_NOTE_ON  = 8'h80;
    localparam logic [7:0] CMD_NOTE_OFF = 8'h90;
    localparam logic [7:0] CMD_VOLUME   = 8'hA0;
    localparam logic [7:0] CMD_GROUP    = 8'hF0;
    localparam logic [7:0] CMD_STOP     = 8'hFE;
    localparam logic [7:0] CMD_LOOP     = 8'hFF;

    localparam logic [1:0] CH_WAVE  = 2'd2;
    localparam logic [1:0] CH_NOISE = 2'd3;

    typedef struct packed {
        logic        has_note;
        logic [1:0]  channel;
        logic [8:0]  pitch;
        logic [15:0] held_length;
        logic [15:0] gap_before;
        logic        first_on_channel;
        logic        song_end;
    } note_rec_t;

    typedef struct packed {
        logic      valid;
        note_rec_t rec;
    } rec_push_t;

endpackage

/* rtl/core/msne_track.sv */
// ----------------------------------------------------------------------------
// msne_track - sequence decoder and per-channel note state
// Decodes one byte per transaction, updates counters, emits single notes.
// ----------------------------------------------------------------------------
module msne_track #(
    parameter int CHANNELS   = msne_pkg::CHANNELS_DEF,
    parameter int COUNT_BITS = msne_pkg::COUNT_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [msne_pkg::CFG_IDX_W-1:0] cfg_wr_idx,
    input  logic [msne_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           in_fire,
    input  logic [7:0]                     in_byte,
    output msne_pkg::rec_push_t            push,
    output logic                           flush_load,
    output logic [CHANNELS-1:0]            flush_mask,
    output msne_pkg::note_rec_t            flush_rec [CHANNELS]
);
    import msne_pkg::*;

    localparam int SUM_W = COUNT_BITS + 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {OP_NONE, OP_PITCH, OP_VOLUME} op_wait_t;

    op_wait_t                  op_wait_reg, op_wait_next;
    logic [1:0]                op_chan_reg, op_chan_next;
    logic [CFG_DATA_W-1:0]     sq_off_reg, sq_off_next;
    logic [CFG_DATA_W-1:0]     wv_off_reg, wv_off_next;
    logic [CHANNELS-1:0]       sounding_reg, sounding_next;
    logic [CHANNELS-1:0]       first_reg, first_next;
    logic [8:0]                pitch_reg [CHANNELS];
    logic [8:0]                pitch_next [CHANNELS];
    logic [COUNT_BITS-1:0]     hold_reg [CHANNELS];
    logic [COUNT_BITS-1:0]     hold_next [CHANNELS];
    logic [COUNT_BITS-1:0]     gap_reg [CHANNELS];
    logic [COUNT_BITS-1:0]     gap_next [CHANNELS];
    logic [SUM_W-1:0]          hold_sum [CHANNELS];
    logic [SUM_W-1:0]          gap_sum [CHANNELS];
    note_rec_t                 rec_all [CHANNELS];
    note_rec_t                 cmd_rec;
    logic [CHANNELS-1:0]       cmd_hit, op_hit;
    logic [1:0]                cmd_chan;
    logic [CFG_DATA_W-1:0]     op_offset;
    logic [8:0]                pitch_sum;

    assign cmd_chan = in_byte[1:0];

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            cmd_hit[c] = (c < ADDR_CHANNELS) && (cmd_chan == 2'(c));
            op_hit[c]  = (c < ADDR_CHANNELS) && (op_chan_reg == 2'(c));
            hold_sum[c] = SUM_W'(hold_reg[c]) + SUM_W'(in_byte[6:0]);
            gap_sum[c]  = SUM_W'(gap_reg[c]) + SUM_W'(in_byte[6:0]);
            rec_all[c].has_note         = 1'b1;
            rec_all[c].channel          = 2'(c);
            rec_all[c].pitch            = pitch_reg[c];
            rec_all[c].held_length      = 16'(hold_reg[c]);
            rec_all[c].gap_before       = 16'(gap_reg[c]);
            rec_all[c].first_on_channel = first_reg[c];
            rec_all[c].song_end         = 1'b0;
        end
    end

    // note of the addressed channel, one-hot select
    always_comb begin
        cmd_rec = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (cmd_hit[c]) begin
                cmd_rec = cmd_rec | rec_all[c];
            end
        end
    end

    always_comb begin
        if (op_chan_reg == CH_NOISE) begin
            op_offset = '0;
        end else if (op_chan_reg == CH_WAVE) begin
            op_offset = wv_off_reg;
        end else begin
            op_offset = sq_off_reg;
        end
        pitch_sum = 9'(in_byte) + 9'(op_offset);
    end

    assign flush_mask = sounding_reg;
    assign flush_rec  = rec_all;

    always_comb begin
        op_wait_next  = op_wait_reg;
        op_chan_next  = op_chan_reg;
        sq_off_next   = sq_off_reg;
        wv_off_next   = wv_off_reg;
        sounding_next = sounding_reg;
        first_next    = first_reg;
        pitch_next    = pitch_reg;
        hold_next     = hold_reg;
        gap_next      = gap_reg;
        push          = '0;
        flush_load    = 1'b0;

        if (cfg_wr_en) begin
            case (cfg_wr_idx)
                CFG_SQUARE_OFFSET: sq_off_next = cfg_wr_data;
                CFG_WAVE_OFFSET:   wv_off_next = cfg_wr_data;
                default: ;
            endcase
        end

        if (in_fire) begin
            case (op_wait_reg)
                OP_PITCH: begin
                    op_wait_next = OP_NONE;
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (op_hit[c]) begin
                            pitch_next[c]    = pitch_sum;
                            sounding_next[c] = 1'b1;
                            hold_next[c]     = '0;
                        end
                    end
                end
                OP_VOLUME: begin
                    op_wait_next = OP_NONE;
                end
                default: begin
                    if (in_byte <= DURATION_MAX) begin
                        for (int c = 0; c < CHANNELS; c++) begin
                            if (sounding_reg[c]) begin
                                hold_next[c] = hold_sum[c][COUNT_BITS] ? CNT_MAX
                                                                       : hold_sum[c][COUNT_BITS-1:0];
                            end else begin
                                gap_next[c] = gap_sum[c][COUNT_BITS] ? CNT_MAX
                                                                     : gap_sum[c][COUNT_BITS-1:0];
                            end
                        end
                    end else begin
                        case (in_byte & CMD_GROUP)
                            CMD_NOTE_ON, CMD_NOTE_OFF: begin
                                if ((in_byte & CMD_GROUP) == CMD_NOTE_ON) begin
                                    op_chan_next = cmd_chan;
                                    op_wait_next = OP_PITCH;
                                end
                                if (|(cmd_hit & sounding_reg)) begin
                                    push.valid = 1'b1;
                                    push.rec   = cmd_rec;
                                end
                                for (int c = 0; c < CHANNELS; c++) begin
                                    if (cmd_hit[c] && sounding_reg[c]) begin
                                        first_next[c]    = 1'b0;
                                        gap_next[c]      = '0;
                                        sounding_next[c] = 1'b0;
                                    end
                                end
                            end
                            CMD_VOLUME: begin
                                op_wait_next = OP_VOLUME;
                            end
                            default: begin
                                if (in_byte inside {CMD_STOP, CMD_LOOP}) begin
                                    // sounding notes go to the flush sequencer
                                    if (sounding_reg == '0) begin
                                        push.valid        = 1'b1;
                                        push.rec.song_end = 1'b1;
                                    end else begin
                                        flush_load = 1'b1;
                                    end
                                    op_wait_next  = OP_NONE;
                                    op_chan_next  = '0;
                                    sounding_next = '0;
                                    first_next    = '1;
                                    for (int c = 0; c < CHANNELS; c++) begin
                                        pitch_next[c] = '0;
                                        hold_next[c]  = '0;
                                        gap_next[c]   = '0;
                                    end
                                end
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_wait_reg  <= OP_NONE;
            op_chan_reg  <= '0;
            sq_off_reg   <= SQUARE_OFFSET_RST;
            wv_off_reg   <= WAVE_OFFSET_RST;
            sounding_reg <= '0;
            first_reg    <= '1;
            for (int c = 0; c < CHANNELS; c++) begin
                pitch_reg[c] <= '0;
                hold_reg[c]  <= '0;
                gap_reg[c]   <= '0;
            end
        end else begin
            op_wait_reg  <= op_wait_next;
            op_chan_reg  <= op_chan_next;
            sq_off_reg   <= sq_off_next;
            wv_off_reg   <= wv_off_next;
            sounding_reg <= sounding_next;
            first_reg    <= first_next;
            pitch_reg    <= pitch_next;
            hold_reg     <= hold_next;
            gap_reg      <= gap_next;
        end
    end

endmodule

/* rtl/core/msne_flush.sv */
// ----------------------------------------------------------------------------
// msne_flush - song end flush sequencer
// Holds a snapshot of sounding notes and issues them lowest channel first.
// ----------------------------------------------------------------------------
module msne_flush #(
    parameter int CHANNELS = msne_pkg::CHANNELS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  logic [CHANNELS-1:0] load_mask,
    input  msne_pkg::note_rec_t load_rec [CHANNELS],
    input  logic                room,
    output msne_pkg::rec_push_t push,
    output logic                busy
);
    import msne_pkg::*;

    logic [CHANNELS-1:0] mask_reg, mask_next;
    note_rec_t           rec_reg [CHANNELS];
    logic [CHANNELS-1:0] pick, rest;
    note_rec_t           sel_rec;

    assign busy = |mask_reg;
    assign pick = mask_reg & (~mask_reg + CHANNELS'(1));
    assign rest = mask_reg & ~pick;

    always_comb begin
        sel_rec = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (pick[c]) begin
                sel_rec = sel_rec | rec_reg[c];
            end
        end
        push.valid        = busy && room;
        push.rec          = sel_rec;
        push.rec.song_end = (rest == '0);   // last flushed note closes the song
    end

    always_comb begin
        if (load) begin
            mask_next = load_mask;
        end else if (push.valid) begin
            mask_next = rest;
        end else begin
            mask_next = mask_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rec_reg <= load_rec;
        end
    end

endmodule

/* rtl/core/msne_fifo.sv */
// ----------------------------------------------------------------------------
// msne_fifo - result queue
// Small register queue between the decoder and the result channel.
// ----------------------------------------------------------------------------
module msne_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  msne_pkg::rec_push_t push,
    input  logic                pop,
    output msne_pkg::note_rec_t head,
    output logic                not_empty,
    output logic                full
);
    import msne_pkg::*;

    localparam int PTR_W = (RESULT_DEPTH > 1) ? $clog2(RESULT_DEPTH) : 1;
    localparam int CNT_W = $clog2(RESULT_DEPTH + 1);

    note_rec_t          mem [RESULT_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(RESULT_DEPTH));
    assign head      = mem[rd_ptr_reg];
    assign do_push   = push.valid && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(RESULT_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(RESULT_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push.rec;
        end
    end

endmodule

/* rtl/core/music_sequence_note_extractor.sv */
// ----------------------------------------------------------------------------
// music_sequence_note_extractor - note records from a four-channel sequence
// Byte-stream decoder that turns sequence commands into finished notes.
// ----------------------------------------------------------------------------
// One sequence byte is taken per transaction and decoded in the cycle it is
// accepted; any note it finishes lands in a two-entry result queue, so a new
// byte is accepted every cycle while the queue has room and no flush runs,
// independent of m_ready in that cycle. For a stop or loop byte (0xFE/0xFF)
// the flush sequencer issues sounding notes one per cycle while the queue has
// room; s_ready stays low until the last one (flagged song_end) is queued. With
// nothing sounding a stop gives one empty result with only song_end set.
// Durations saturate at 2^COUNT_BITS-1; the output length fields carry the low
// 16 bits. The user must write pitch offsets via cfg_wr_* (index 0 square
// channels, 1 wave channel) only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module music_sequence_note_extractor #(
    parameter int CHANNELS   = msne_pkg::CHANNELS_DEF,
    parameter int COUNT_BITS = msne_pkg::COUNT_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [msne_pkg::CFG_IDX_W-1:0]  cfg_wr_idx,
    input  logic [msne_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    // sequence bytes in
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_seq_byte,
    // note records out
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_has_note,
    output logic [1:0]                      m_channel,
    output logic [8:0]                      m_pitch,
    output logic [15:0]                     m_held_length,
    output logic [15:0]                     m_gap_before,
    output logic                            m_first_on_channel,
    output logic                            m_song_end
);
    import msne_pkg::*;

    logic                in_fire;
    rec_push_t           track_push, flush_push, fifo_push;
    logic                flush_load, flush_busy;
    logic [CHANNELS-1:0] flush_mask;
    note_rec_t           flush_rec [CHANNELS];
    note_rec_t           head;
    logic                fifo_full;

    // input side only waits on queue space and an active flush
    assign s_ready = !fifo_full && !flush_busy;
    assign in_fire = s_valid && s_ready;

    msne_track #(
        .CHANNELS   (CHANNELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_track (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_idx  (cfg_wr_idx),
        .cfg_wr_data (cfg_wr_data),
        .in_fire     (in_fire),
        .in_byte     (s_seq_byte),
        .push        (track_push),
        .flush_load  (flush_load),
        .flush_mask  (flush_mask),
        .flush_rec   (flush_rec)
    );

    msne_flush #(
        .CHANNELS (CHANNELS)
    ) u_flush (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (flush_load),
        .load_mask (flush_mask),
        .load_rec  (flush_rec),
        .room      (!fifo_full),
        .push      (flush_push),
        .busy      (flush_busy)
    );

    // the decoder and the flush sequencer never push in the same cycle
    assign fifo_push = track_push.valid ? track_push : flush_push;

    msne_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fifo_push),
        .pop       (m_ready),
        .head      (head),
        .not_empty (m_valid),
        .full      (fifo_full)
    );

    assign m_has_note         = head.has_note;
    assign m_channel          = head.channel;
    assign m_pitch            = head.pitch;
    assign m_held_length      = head.held_length;
    assign m_gap_before       = head.gap_before;
    assign m_first_on_channel = head.first_on_channel;
    assign m_song_end         = head.song_end;

endmodule

/* rtl/core/msne_checker.sv */
// ----------------------------------------------------------------------------
// msne_checker - port-level checks for the note extractor
// Watches both channels and is bound to the top level.
// ----------------------------------------------------------------------------
module msne_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_seq_byte,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_has_note,
    input logic [1:0]  m_channel,
    input logic [8:0]  m_pitch,
    input logic [15:0] m_held_length,
    input logic [15:0] m_gap_before,
    input logic        m_first_on_channel,
    input logic        m_song_end
);

    // a waiting sequence byte is held until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_seq_byte))
        else $error("input transaction changed while waiting");

    // a result without a note is only the empty song-end marker
    a_empty_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_note |-> m_song_end && m_channel == 2'd0 && m_pitch == 9'd0
            && m_held_length == 16'd0 && m_gap_before == 16'd0 && !m_first_on_channel)
        else $error("empty result carries note fields");

    // noise channel has no pitch offset
    a_noise_pitch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_has_note && m_channel == 2'd3 |-> !m_pitch[8])
        else $error("noise pitch above byte range");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_has_note) && $stable(m_channel)
            && $stable(m_pitch) && $stable(m_held_length) && $stable(m_gap_before)
            && $stable(m_first_on_channel) && $stable(m_song_end))
        else $error("result changed while stalled");

endmodule

bind music_sequence_note_extractor msne_checker u_msne_checker (.*);

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench - self-checking bench for music_sequence_note_extractor
// Drives sequence bytes over the valid/ready input channel, predicts every
// note record with a scoreboard that tracks the four channels, and checks
// each record taken from the output channel field by field.
// ----------------------------------------------------------------------------
module testbench;
    import msne_pkg::*;

    // Cycles with no transaction on either channel before the run is abandoned.
    // This leaves a wide margin over receiver stalls at 81 % idling.
    localparam int STALL_LIMIT = 2000;
    // Settling time after the last expected record, before a register write
    // and at the end of the run (flush sequencer plus the result queue).
    localparam int SETTLE_CYCLES = 12;

    typedef enum logic [1:0] {
        OPW_NONE,
        OPW_PITCH,
        OPW_VOLUME
    } operand_wait_t;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the sequence state of every channel, builds the
    // note records a byte finishes, and checks the records coming out.
    // ------------------------------------------------------------------------
    class note_scoreboard;
        logic [6:0]    square_ofs;
        logic [6:0]    wave_ofs;
        logic [3:0]    sounding;
        logic [3:0]    first_pending;
        logic [8:0]    held_pitch [4];
        logic [15:0]   hold_count [4];
        logic [15:0]   gap_count [4];
        operand_wait_t op_wait;
        logic [1:0]    op_chan;
        note_rec_t     expected_notes [$];
        int            errors;

        function new();
            square_ofs = SQUARE_OFFSET_RST;
            wave_ofs   = WAVE_OFFSET_RST;
            errors     = 0;
            clear_song();
        endfunction

        function void clear_song();
            for (int c = 0; c < 4; c++) begin
                held_pitch[c] = '0;
                hold_count[c] = '0;
                gap_count[c]  = '0;
            end
            sounding      = '0;
            first_pending = '1;
            op_wait       = OPW_NONE;
            op_chan       = '0;
        endfunction

        function void set_offset(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_SQUARE_OFFSET) begin
                square_ofs = data;
            end else if (idx == CFG_WAVE_OFFSET) begin
                wave_ofs = data;
            end
        endfunction

        function logic [6:0] offset_for(logic [1:0] ch);
            if (ch == CH_NOISE) begin
                return '0;
            end else if (ch == CH_WAVE) begin
                return wave_ofs;
            end
            return square_ofs;
        endfunction

        function logic [15:0] sat_add(logic [15:0] cnt, logic [7:0] dur);
            logic [16:0] sum;
            sum = {1'b0, cnt} + 17'(dur);
            return sum[16] ? 16'hFFFF : sum[15:0];
        endfunction

        // Queue the record for a finished note and silence the channel
        function void finish_note(int ch, logic last);
            note_rec_t rec;
            rec                  = '0;
            rec.has_note         = 1'b1;
            rec.channel          = 2'(ch);
            rec.pitch            = held_pitch[ch];
            rec.held_length      = hold_count[ch];
            rec.gap_before       = gap_count[ch];
            rec.first_on_channel = first_pending[ch];
            rec.song_end         = last;
            expected_notes.push_back(rec);
            first_pending[ch] = 1'b0;
            gap_count[ch]     = '0;
            sounding[ch]      = 1'b0;
        endfunction

        // One accepted sequence byte
        function void note_byte(logic [7:0] b);
            logic [1:0] ch;
            note_rec_t  rec;
            int         left;
            ch = b[1:0];
            if (op_wait == OPW_PITCH) begin
                // operand of a note-on, whatever it looks like
                op_wait             = OPW_NONE;
                held_pitch[op_chan] = 9'(b) + 9'(offset_for(op_chan));
                sounding[op_chan]   = 1'b1;
                hold_count[op_chan] = '0;
            end else if (op_wait == OPW_VOLUME) begin
                op_wait = OPW_NONE;
            end else if (b <= DURATION_MAX) begin
                for (int c = 0; c < 4; c++) begin
                    if (sounding[c]) begin
                        hold_count[c] = sat_add(hold_count[c], b);
                    end else begin
                        gap_count[c] = sat_add(gap_count[c], b);
                    end
                end
            end else if ((b & CMD_GROUP) == CMD_NOTE_ON) begin
                if (sounding[ch]) begin
                    finish_note(ch, 1'b0);
                end
                op_chan = ch;
                op_wait = OPW_PITCH;
            end else if ((b & CMD_GROUP) == CMD_NOTE_OFF) begin
                if (sounding[ch]) begin
                    finish_note(ch, 1'b0);
                end
            end else if ((b & CMD_GROUP) == CMD_VOLUME) begin
                op_wait = OPW_VOLUME;
            end else if (b == CMD_STOP || b == CMD_LOOP) begin
                // flush in channel order; song_end rides on the last record
                left = $countones(sounding);
                if (left == 0) begin
                    rec          = '0;
                    rec.song_end = 1'b1;
                    expected_notes.push_back(rec);
                end
                for (int c = 0; c < 4; c++) begin
                    if (sounding[c]) begin
                        left--;
                        finish_note(c, left == 0);
                    end
                end
                clear_song();
            end
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_record(note_rec_t got);
            note_rec_t want;
            if (expected_notes.size() == 0) begin
                $display("%0t: unexpected record, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_notes.pop_front();
            compare_field("has_note", want.has_note, got.has_note);
            compare_field("channel", want.channel, got.channel);
            compare_field("pitch", want.pitch, got.pitch);
            compare_field("held_length", want.held_length, got.held_length);
            compare_field("gap_before", want.gap_before, got.gap_before);
            compare_field("first_on_channel", want.first_on_channel, got.first_on_channel);
            compare_field("song_end", want.song_end, got.song_end);
        endfunction

        function int waiting();
            return expected_notes.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_seq_byte  = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic                  m_has_note;
    logic [1:0]            m_channel;
    logic [8:0]            m_pitch;
    logic [15:0]           m_held_length;
    logic [15:0]           m_gap_before;
    logic                  m_first_on_channel;
    logic                  m_song_end;
    note_rec_t             out_rec;

    note_scoreboard sb;
    int send_idle_pct = 16;
    int recv_idle_pct = 81;
    int stall_cycles  = 0;

    always #5 aclk = ~aclk;

    assign out_rec = {m_has_note, m_channel, m_pitch, m_held_length, m_gap_before,
                      m_first_on_channel, m_song_end};

    music_sequence_note_extractor u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_idx         (cfg_wr_idx),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_seq_byte         (s_seq_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_has_note         (m_has_note),
        .m_channel          (m_channel),
        .m_pitch            (m_pitch),
        .m_held_length      (m_held_length),
        .m_gap_before       (m_gap_before),
        .m_first_on_channel (m_first_on_channel),
        .m_song_end         (m_song_end)
    );

    // ------------------------------------------------------------------------
    // Result side: values are read just after the rising edge, before any
    // nonblocking update lands, so they are the ones the DUT saw at the edge.
    // m_ready is redrawn every cycle to throttle the result channel.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                sb.check_record(out_rec);
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: a run that stops moving counts as a failure
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // One sequence byte as one transaction, after a random idle gap. Valid is
    // only lowered for a gap, never dropped and raised again in one step.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_seq_byte <= b;
        do begin
            @(posedge aclk);
        end while (!(s_valid && s_ready));
        sb.note_byte(b);
    endtask

    // Drain: every expected record out, then let the flush sequencer settle
    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (sb.waiting() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Both pitch offsets, on consecutive edges while the block is idle
    task automatic write_offsets(input logic [6:0] square_ofs, input logic [6:0] wave_ofs);
        cfg_wr_en   <= 1'b1;
        cfg_wr_idx  <= CFG_SQUARE_OFFSET;
        cfg_wr_data <= square_ofs;
        @(posedge aclk);
        sb.set_offset(CFG_SQUARE_OFFSET, square_ofs);
        cfg_wr_idx  <= CFG_WAVE_OFFSET;
        cfg_wr_data <= wave_ofs;
        @(posedge aclk);
        sb.set_offset(CFG_WAVE_OFFSET, wave_ofs);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly well-formed sequence fragments with random content; a share of
    // ignored bytes and stray bytes that break a pairing (a lone note-on
    // swallows whatever follows as its pitch).
    task automatic play_random_song(input int fragments);
        int pick;
        for (int i = 0; i < fragments; i++) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                send_byte(CMD_NOTE_ON | 8'($urandom_range(15)));
                send_byte(8'($urandom_range(255)));
            end else if (pick < 58) begin
                send_byte($urandom_range(3) == 0 ? DURATION_MAX
                                                 : 8'($urandom_range(DURATION_MAX)));
            end else if (pick < 74) begin
                send_byte(CMD_NOTE_OFF | 8'($urandom_range(15)));
            end else if (pick < 81) begin
                send_byte(CMD_VOLUME | 8'($urandom_range(15)));
                send_byte(8'($urandom_range(255)));
            end else if (pick < 86) begin
                send_byte($urandom_range(1) ? CMD_STOP : CMD_LOOP);
            end else if (pick < 93) begin
                send_byte(8'($urandom_range(8'hFD, 8'hB0)));
            end else begin
                send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, reset offsets. Sender idles lightly, receiver heavily.
        send_byte(CMD_STOP);                 // stop with nothing sounding
        send_byte(CMD_NOTE_ON | 8'h00);      // square ch0, lowest pitch byte
        send_byte(8'h00);
        send_byte(CMD_NOTE_ON | 8'h0D);      // ch1 with upper low-nibble bits set
        send_byte(8'hFF);                    // highest pitch byte
        send_byte(CMD_NOTE_ON | 8'h02);      // wave channel
        send_byte(CMD_NOTE_OFF);             // operand that looks like a command
        send_byte(CMD_NOTE_ON | 8'h07);      // noise channel, no offset
        send_byte(DURATION_MAX);
        send_byte(8'h00);                    // zero duration
        send_byte(CMD_NOTE_ON | 8'h00);      // retrigger: ch0 note out first
        send_byte(CMD_STOP);                 // pitch operand, not a stop
        send_byte(CMD_NOTE_OFF | 8'h01);     // ch1 off
        send_byte(CMD_NOTE_OFF | 8'h0D);     // ch1 again, already silent
        send_byte(CMD_VOLUME | 8'h05);       // volume operand skipped ...
        send_byte(CMD_LOOP);                 // ... even when it reads as loop
        send_byte(8'hB3);                    // ignored bytes
        send_byte(CMD_GROUP);
        send_byte(8'hFD);
        send_byte(8'h05);
        send_byte(CMD_LOOP);                 // loop flushes ch0, ch2 and ch3
        send_byte(CMD_NOTE_ON | 8'h01);      // fill all four, then stop
        send_byte(8'h40);
        send_byte(CMD_NOTE_ON | 8'h03);
        send_byte(8'h41);
        send_byte(CMD_NOTE_ON | 8'h00);
        send_byte(8'h42);
        send_byte(CMD_NOTE_ON | 8'h02);
        send_byte(8'h43);
        send_byte(8'h10);
        send_byte(CMD_STOP);                 // four records, song end on the last

        // Phase 1: offset extremes, same idling
        wait_quiet();
        write_offsets(7'd0, 7'd127);
        play_random_song(40);

        // Phase 2: sender idles heavily, receiver lightly
        send_idle_pct = 81;
        recv_idle_pct = 16;
        wait_quiet();
        write_offsets(7'd127, 7'd0);
        // a held note across several long rests
        send_byte(CMD_NOTE_ON | 8'h00);
        send_byte(8'($urandom_range(255)));
        repeat (4) send_byte(DURATION_MAX);
        send_byte(CMD_NOTE_OFF | 8'h00);
        send_byte(CMD_NOTE_ON | 8'h01);
        send_byte(8'($urandom_range(255)));
        send_byte(8'h01);
        send_byte(CMD_STOP);
        play_random_song(40);

        // Phase 3: no idling on either side, random offsets
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_quiet();
        write_offsets(7'($urandom_range(127)), 7'($urandom_range(127)));
        play_random_song(30);

        wait_quiet();
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
